// ===== hw/rtl/windowed_section_time_profiler_assert.svh =====
// Assertion macros for the windowed section time profiler.
// Every macro expects signals named clk and rst_n in the including module.
`ifndef WINDOWED_SECTION_TIME_PROFILER_ASSERT_SVH
`define WINDOWED_SECTION_TIME_PROFILER_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define WSP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition on one edge implies a condition on the next edge.
`define WSP_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hw/rtl/wsp_pkg.sv =====
// Shared types, constants and codes for the windowed section time profiler.
// No dependencies; imported by every other file but wsp_ram and the assertion header.
`timescale 1ns / 1ps

package wsp_pkg;

  localparam int unsigned NUM_CATS         = 13;
  localparam int unsigned CAT_W            = 4;
  localparam int unsigned DATA_W           = 32;
  localparam int unsigned DEF_WINDOW_DEPTH = 16;
  localparam int unsigned RSP_TASKS        = 2;
  localparam int unsigned IDX_W            = 3;

  typedef logic [CAT_W-1:0]  cat_t;
  typedef logic [DATA_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  idx_t;

  localparam cat_t CAT_COUNT    = cat_t'(NUM_CATS);
  localparam cat_t CAT_FPS      = 4'd0;
  localparam cat_t CAT_AUDIO    = 4'd6;
  localparam cat_t CAT_TOTAL    = 4'd7;
  localparam cat_t CAT_RSP_BASE = 4'd8;
  localparam cat_t CAT_TMEM     = 4'd10;
  localparam cat_t CAT_CMD      = 4'd11;
  localparam cat_t CAT_PIPE     = 4'd12;

  // results per event
  localparam idx_t ONE_RESULT    = 3'd1;
  localparam idx_t FRAME_RESULTS = 3'd5;

  typedef enum logic [2:0] {
    REQ_SECTION_END = 3'd0,
    REQ_RSP_START   = 3'd1,
    REQ_RSP_DONE    = 3'd2,
    REQ_RSP_RESUME  = 3'd3,
    REQ_AUDIO_START = 3'd4,
    REQ_AUDIO_DONE  = 3'd5,
    REQ_FRAME_END   = 3'd6,
    REQ_FRAME_SETUP = 3'd7
  } req_type_t;

  typedef enum logic [1:0] {
    W_IDLE,
    W_READ,
    W_DIV,
    W_DONE
  } win_state_t;

  typedef enum logic {
    T_IDLE,
    T_RUN
  } top_state_t;

  // sequencer -> window unit
  typedef struct packed {
    logic  start;
    cat_t  cat;
    word_t value;
    logic  last;
  } upd_req_t;

  // window unit -> sequencer
  typedef struct packed {
    logic  ready;
    logic  clearing;
    logic  done;
    cat_t  cat;
    word_t value;
    word_t total;
    word_t average;
    logic  last;
  } upd_rsp_t;

  // category of each frame_end result, in delivery order
  function automatic cat_t frame_cat(input idx_t idx);
    cat_t c;
    case (idx)
      3'd0:    c = CAT_FPS;
      3'd1:    c = CAT_TOTAL;
      3'd2:    c = CAT_TMEM;
      3'd3:    c = CAT_CMD;
      default: c = CAT_PIPE;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/wsp_ifs.sv =====
// Valid/ready channel interfaces for the profiler's event input and result output.
// Depends on wsp_pkg.
`timescale 1ns / 1ps

interface wsp_in_if import wsp_pkg::*;;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  cat_t       category;
  logic       rsp_task;
  word_t      timestamp;
  word_t      tmem_count;
  word_t      cmd_count;
  word_t      pipe_count;

  modport source (output valid, req_type, category, rsp_task, timestamp,
                  tmem_count, cmd_count, pipe_count, input ready);
  modport sink   (input valid, req_type, category, rsp_task, timestamp,
                  tmem_count, cmd_count, pipe_count, output ready);
endinterface

interface wsp_out_if import wsp_pkg::*;;
  logic  valid;
  logic  ready;
  cat_t  out_category;
  word_t sample_value;
  word_t window_total;
  word_t window_average;
  logic  last_result;

  modport source (output valid, out_category, sample_value, window_total,
                  window_average, last_result, input ready);
  modport sink   (input valid, out_category, sample_value, window_total,
                  window_average, last_result, output ready);
endinterface

// ===== hw/rtl/wsp_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module wsp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/wsp_avg.sv =====
// Two-stage divide of a window total by the constant window depth.
// Reciprocal multiply, then one correction step. Depends on wsp_pkg.
`timescale 1ns / 1ps

module wsp_avg import wsp_pkg::*; #(
  parameter int unsigned DIVISOR = DEF_WINDOW_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  vld_i,
  input  word_t x_i,
  output logic  vld_o,
  output word_t q_o
);

  // RECIP < 2^32 for any divisor; estimate is exact or one low
  localparam int unsigned SH    = 31 + $clog2(DIVISOR);
  localparam word_t       RECIP = 32'((64'd1 << SH) / DIVISOR);
  localparam word_t       DIV_W = 32'(DIVISOR);

  logic [63:0] prod;
  word_t       q0_r, x_r, q_r, q_nxt, qd, rem;
  logic        v1_r, v2_r;

  assign prod  = 64'(x_i) * 64'(RECIP);
  assign qd    = q0_r * DIV_W;
  assign rem   = x_r - qd;
  assign q_nxt = (rem >= DIV_W) ? q0_r + 32'd1 : q0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= vld_i;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    q0_r <= 32'(prod >> SH);
    x_r  <= x_i;
    q_r  <= q_nxt;
  end

  assign vld_o = v2_r;
  assign q_o   = q_r;

endmodule

// ===== hw/rtl/wsp_window.sv =====
// Window update unit: sample RAM read-modify-write, per-category totals, average.
// Sweeps the sample RAM to zero after reset. Depends on wsp_pkg, wsp_ram, wsp_avg.
`timescale 1ns / 1ps
`include "windowed_section_time_profiler_assert.svh"

module wsp_window import wsp_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = DEF_WINDOW_DEPTH,
  localparam int unsigned SLOT_W      = $clog2(WINDOW_DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  upd_req_t          req_i,
  input  logic [SLOT_W-1:0] slot_i,
  output upd_rsp_t          rsp_o
);

  localparam int unsigned DEPTH     = NUM_CATS * WINDOW_DEPTH;
  localparam int unsigned AW        = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  win_state_t    state_r, state_nxt;
  logic          clr_r;
  logic [AW-1:0] clr_addr_r;
  cat_t          cat_r;
  word_t         value_r;
  word_t         tot_r;
  logic          last_r;
  logic [AW-1:0] addr_r;
  logic [AW-1:0] rd_addr;
  word_t         totals_r [NUM_CATS];
  word_t         rdata, tot_nxt, avg_q;
  logic          avg_vld;
  logic          we;
  logic [AW-1:0] waddr;
  word_t         wdata;

  assign rd_addr = AW'(req_i.cat) * AW'(WINDOW_DEPTH) + AW'(slot_i);
  assign tot_nxt = totals_r[cat_r] - rdata + value_r;

  always_comb begin
    state_nxt = state_r;
    we        = clr_r;
    waddr     = clr_addr_r;
    wdata     = '0;
    case (state_r)
      W_IDLE: begin
        if (req_i.start) begin
          state_nxt = W_READ;
        end
      end
      W_READ: begin
        // old slot value is on rdata: write the new sample back
        we        = 1'b1;
        waddr     = addr_r;
        wdata     = value_r;
        state_nxt = W_DIV;
      end
      W_DIV:   state_nxt = W_DONE;
      W_DONE:  state_nxt = W_IDLE;
      default: state_nxt = W_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= W_IDLE;
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
      for (int i = 0; i < NUM_CATS; i++) begin
        totals_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == LAST_ADDR) begin
          clr_r <= 1'b0;
        end
      end
      if (state_r == W_READ) begin
        totals_r[cat_r] <= tot_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_i.start) begin
      cat_r   <= req_i.cat;
      value_r <= req_i.value;
      last_r  <= req_i.last;
      addr_r  <= rd_addr;
    end
    if (state_r == W_READ) begin
      tot_r <= tot_nxt;
    end
  end

  wsp_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (req_i.start),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  wsp_avg #(
    .DIVISOR (WINDOW_DEPTH)
  ) u_avg (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (state_r == W_READ),
    .x_i   (tot_nxt),
    .vld_o (avg_vld),
    .q_o   (avg_q)
  );

  assign rsp_o.ready    = (state_r == W_IDLE) && !clr_r;
  assign rsp_o.clearing = clr_r;
  assign rsp_o.done     = (state_r == W_DONE);
  assign rsp_o.cat      = cat_r;
  assign rsp_o.value    = value_r;
  assign rsp_o.total    = tot_r;
  assign rsp_o.average  = avg_q;
  assign rsp_o.last     = last_r;

  `WSP_ASSERT(a_avg_aligned, ((state_r == W_DONE) == avg_vld), "average not aligned with done")
  `WSP_ASSERT(a_start_idle, req_i.start |-> (state_r == W_IDLE && !clr_r), "start while busy")
  `WSP_ASSERT_NEXT(a_clear_ends, clr_r && clr_addr_r == LAST_ADDR, !clr_r, "clear pass overran")

endmodule

// ===== hw/rtl/windowed_section_time_profiler.sv =====
// Top level of the windowed section time profiler: event decode, timing state, sequencing.
// Depends on wsp_pkg, wsp_ifs, wsp_window.
`timescale 1ns / 1ps
`include "windowed_section_time_profiler_assert.svh"

// Takes timestamped profiling events and keeps a sliding window of WINDOW_DEPTH
// samples per time category in one sample RAM, with a running total per category.
// Each sample written comes out as one result item with the new total and the
// average (total / WINDOW_DEPTH). Events that produce no result are taken without
// entering the run state. Each result passes the read-modify-write of the sample
// RAM (read, write-back) and a two-stage reciprocal divide, then the output
// register hand-off. A frame_end makes five results. The next event is taken
// while the last result still waits in the output register. After reset the
// sample RAM is swept to zero, all 13 * WINDOW_DEPTH entries (208 at the default
// depth), during which no event is accepted.

module windowed_section_time_profiler import wsp_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
  input logic       clk,
  input logic       rst_n,
  wsp_in_if.sink    in_ch,
  wsp_out_if.source out_ch
);

  localparam int unsigned       SLOT_W    = $clog2(WINDOW_DEPTH);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == SLOT_LAST) ? '0 : s + SLOT_W'(1);
  endfunction

  top_state_t        t_state_r, t_state_nxt;
  logic [SLOT_W-1:0] frame_slot_r, frame_slot_nxt;
  logic [SLOT_W-1:0] rsp_slot_r [RSP_TASKS];
  logic [SLOT_W-1:0] rsp_slot_nxt [RSP_TASKS];
  logic [SLOT_W-1:0] audio_slot_r, audio_slot_nxt;
  word_t             rsp_pending_r [RSP_TASKS];
  word_t             rsp_pending_nxt [RSP_TASKS];
  word_t             frame_start_r, frame_start_nxt;
  word_t             prior_start_r, prior_start_nxt;
  word_t             last_mark_r, last_mark_nxt;
  word_t             audio_begin_r, audio_begin_nxt;
  word_t             preempt_r, preempt_nxt;
  word_t             val_r [FRAME_RESULTS];
  word_t             val_nxt [FRAME_RESULTS];
  cat_t              cat_r, cat_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  idx_t              n_r, n_nxt;
  idx_t              idx_r, idx_nxt;

  logic              out_valid_r;
  cat_t              out_cat_r;
  word_t             out_value_r, out_total_r, out_avg_r;
  logic              out_last_r;

  logic              in_acc;
  logic              issue;
  logic              rsp_sel;
  logic              n_legal;
  req_type_t         req;
  word_t             ts;
  word_t             audio_sample;
  upd_req_t          win_req;
  upd_rsp_t          win_rsp;

  assign in_ch.ready  = (t_state_r == T_IDLE) && !win_rsp.clearing;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign req          = req_type_t'(in_ch.req_type);
  assign rsp_sel      = in_ch.rsp_task;
  assign ts           = in_ch.timestamp;
  assign audio_sample = ts - audio_begin_r;

  always_comb begin
    t_state_nxt     = t_state_r;
    frame_slot_nxt  = frame_slot_r;
    rsp_slot_nxt    = rsp_slot_r;
    audio_slot_nxt  = audio_slot_r;
    rsp_pending_nxt = rsp_pending_r;
    frame_start_nxt = frame_start_r;
    prior_start_nxt = prior_start_r;
    last_mark_nxt   = last_mark_r;
    audio_begin_nxt = audio_begin_r;
    preempt_nxt     = preempt_r;
    val_nxt         = val_r;
    cat_nxt         = cat_r;
    slot_nxt        = slot_r;
    n_nxt           = n_r;
    idx_nxt         = idx_r;
    issue           = 1'b0;
    case (t_state_r)
      T_IDLE: begin
        if (in_acc) begin
          idx_nxt = '0;
          n_nxt   = ONE_RESULT;
          case (req)
            REQ_SECTION_END: begin
              // out-of-range category: dropped, no state change
              if (in_ch.category < CAT_COUNT) begin
                val_nxt[0]      = ts - last_mark_r - preempt_r;
                frame_start_nxt = frame_start_r + preempt_r;
                preempt_nxt     = '0;
                last_mark_nxt   = ts;
                cat_nxt         = in_ch.category;
                slot_nxt        = frame_slot_r;
                t_state_nxt     = T_RUN;
              end
            end
            REQ_RSP_START: rsp_pending_nxt[rsp_sel] = ts;
            REQ_RSP_DONE: begin
              val_nxt[0]               = ts - rsp_pending_r[rsp_sel];
              rsp_pending_nxt[rsp_sel] = '0;
              cat_nxt                  = CAT_RSP_BASE + cat_t'(rsp_sel);
              slot_nxt                 = rsp_slot_r[rsp_sel];
              rsp_slot_nxt[rsp_sel]    = next_slot(rsp_slot_r[rsp_sel]);
              t_state_nxt              = T_RUN;
            end
            // resume always acts on the graphics task
            REQ_RSP_RESUME:  rsp_pending_nxt[0] = ts - rsp_pending_r[0];
            REQ_AUDIO_START: audio_begin_nxt = ts;
            REQ_AUDIO_DONE: begin
              val_nxt[0]     = audio_sample;
              preempt_nxt    = audio_sample;
              cat_nxt        = CAT_AUDIO;
              slot_nxt       = audio_slot_r;
              audio_slot_nxt = next_slot(audio_slot_r);
              t_state_nxt    = T_RUN;
            end
            REQ_FRAME_END: begin
              val_nxt[0]      = frame_start_r - prior_start_r;
              val_nxt[1]      = ts - (frame_start_r + preempt_r);
              val_nxt[2]      = in_ch.tmem_count;
              val_nxt[3]      = in_ch.cmd_count;
              val_nxt[4]      = in_ch.pipe_count;
              prior_start_nxt = frame_start_r;
              preempt_nxt     = '0;
              last_mark_nxt   = ts;
              slot_nxt        = frame_slot_r;
              n_nxt           = FRAME_RESULTS;
              t_state_nxt     = T_RUN;
            end
            REQ_FRAME_SETUP: begin
              frame_slot_nxt  = next_slot(frame_slot_r);
              preempt_nxt     = '0;
              frame_start_nxt = ts;
              last_mark_nxt   = ts;
            end
            default: ;
          endcase
        end
      end
      T_RUN: begin
        // one update in flight at a time; output register must be free
        if (win_rsp.ready && !out_valid_r) begin
          issue   = 1'b1;
          idx_nxt = idx_r + idx_t'(1);
          if (idx_r == n_r - idx_t'(1)) begin
            t_state_nxt = T_IDLE;
          end
        end
      end
      default: t_state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_state_r     <= T_IDLE;
      frame_slot_r  <= SLOT_LAST;
      audio_slot_r  <= '0;
      frame_start_r <= '0;
      prior_start_r <= '0;
      last_mark_r   <= '0;
      audio_begin_r <= '0;
      preempt_r     <= '0;
      n_r           <= ONE_RESULT;
      idx_r         <= '0;
      for (int i = 0; i < RSP_TASKS; i++) begin
        rsp_slot_r[i]    <= '0;
        rsp_pending_r[i] <= '0;
      end
    end else begin
      t_state_r     <= t_state_nxt;
      frame_slot_r  <= frame_slot_nxt;
      audio_slot_r  <= audio_slot_nxt;
      frame_start_r <= frame_start_nxt;
      prior_start_r <= prior_start_nxt;
      last_mark_r   <= last_mark_nxt;
      audio_begin_r <= audio_begin_nxt;
      preempt_r     <= preempt_nxt;
      n_r           <= n_nxt;
      idx_r         <= idx_nxt;
      rsp_slot_r    <= rsp_slot_nxt;
      rsp_pending_r <= rsp_pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    cat_r  <= cat_nxt;
    slot_r <= slot_nxt;
  end

  assign win_req.start = issue;
  assign win_req.cat   = (n_r == FRAME_RESULTS) ? frame_cat(idx_r) : cat_r;
  assign win_req.value = val_r[idx_r];
  assign win_req.last  = (idx_r == n_r - idx_t'(1));

  wsp_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .req_i  (win_req),
    .slot_i (slot_r),
    .rsp_o  (win_rsp)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (win_rsp.done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (win_rsp.done) begin
      out_cat_r   <= win_rsp.cat;
      out_value_r <= win_rsp.value;
      out_total_r <= win_rsp.total;
      out_avg_r   <= win_rsp.average;
      out_last_r  <= win_rsp.last;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.out_category   = out_cat_r;
  assign out_ch.sample_value   = out_value_r;
  assign out_ch.window_total   = out_total_r;
  assign out_ch.window_average = out_avg_r;
  assign out_ch.last_result    = out_last_r;

  assign n_legal = (n_r == ONE_RESULT) || (n_r == FRAME_RESULTS);

  `WSP_ASSERT(a_done_free, win_rsp.done |-> !out_valid_r, "result would overwrite waiting item")
  `WSP_ASSERT(a_idx_range, (t_state_r == T_RUN) |-> (idx_r < n_r), "result index past count")
  `WSP_ASSERT(a_count_legal, (t_state_r == T_RUN) |-> n_legal, "bad result count")

endmodule

// ===== tb/tb_windowed_section_time_profiler.sv =====
// Testbench for windowed_section_time_profiler: directed and random profiling events,
// scoreboard with its own window/total predictor. Depends on wsp_pkg, wsp_ifs and the RTL.
`timescale 1ns / 1ps

module tb_windowed_section_time_profiler import wsp_pkg::*;;

  localparam int unsigned WIN_DEPTH    = DEF_WINDOW_DEPTH;
  localparam int unsigned ITEM_TARGET  = 470;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned LIMIT_CYCLES = 400000;

  typedef struct {
    req_type_t kind;
    cat_t      category;
    logic      rsp_id;
    word_t     stamp;
    word_t     tmem;
    word_t     cmd;
    word_t     pipe;
  } prof_event_t;

  typedef struct {
    cat_t  cat;
    word_t value;
    word_t total;
    word_t average;
    logic  last;
  } win_result_t;

  class window_scoreboard;
    word_t       samples [NUM_CATS][WIN_DEPTH];
    word_t       totals [NUM_CATS];
    int unsigned frame_slot;
    int unsigned rsp_slot [RSP_TASKS];
    int unsigned audio_slot;
    word_t       rsp_pending [RSP_TASKS];
    word_t       frame_start;
    word_t       prior_frame_start;
    word_t       last_mark;
    word_t       audio_begin;
    word_t       preempt;
    win_result_t pending_samples[$];
    int unsigned errors;

    function new();
      foreach (samples[c, s]) samples[c][s] = '0;
      foreach (totals[c]) totals[c] = '0;
      foreach (rsp_slot[t]) begin
        rsp_slot[t]    = 0;
        rsp_pending[t] = '0;
      end
      frame_slot        = WIN_DEPTH - 1;
      audio_slot        = 0;
      frame_start       = '0;
      prior_frame_start = '0;
      last_mark         = '0;
      audio_begin       = '0;
      preempt           = '0;
      errors            = 0;
    endfunction

    function void put_sample(cat_t c, int unsigned slot, word_t v, logic last);
      win_result_t r;
      totals[c]        = totals[c] - samples[c][slot] + v;
      samples[c][slot] = v;
      r.cat     = c;
      r.value   = v;
      r.total   = totals[c];
      r.average = word_t'(totals[c] / WIN_DEPTH);
      r.last    = last;
      pending_samples.push_back(r);
    endfunction

    function void note_event(prof_event_t ev);
      word_t v;
      word_t pre;
      case (ev.kind)
        REQ_SECTION_END: begin
          // out-of-range categories are dropped without touching state
          if (ev.category < CAT_COUNT) begin
            pre         = preempt;
            preempt     = '0;
            v           = ev.stamp - last_mark - pre;
            frame_start = frame_start + pre;
            put_sample(ev.category, frame_slot, v, 1'b1);
            last_mark   = ev.stamp;
          end
        end
        REQ_RSP_START: rsp_pending[ev.rsp_id] = ev.stamp;
        REQ_RSP_DONE: begin
          v = ev.stamp - rsp_pending[ev.rsp_id];
          rsp_pending[ev.rsp_id] = '0;
          put_sample(cat_t'(CAT_RSP_BASE + ev.rsp_id), rsp_slot[ev.rsp_id], v, 1'b1);
          rsp_slot[ev.rsp_id] = (rsp_slot[ev.rsp_id] + 1) % WIN_DEPTH;
        end
        // resume always acts on the graphics task
        REQ_RSP_RESUME: rsp_pending[0] = ev.stamp - rsp_pending[0];
        REQ_AUDIO_START: audio_begin = ev.stamp;
        REQ_AUDIO_DONE: begin
          v       = ev.stamp - audio_begin;
          preempt = v;
          put_sample(CAT_AUDIO, audio_slot, v, 1'b1);
          audio_slot = (audio_slot + 1) % WIN_DEPTH;
        end
        REQ_FRAME_END: begin
          put_sample(CAT_FPS, frame_slot, frame_start - prior_frame_start, 1'b0);
          prior_frame_start = frame_start;
          pre     = preempt;
          preempt = '0;
          put_sample(CAT_TOTAL, frame_slot, ev.stamp - (frame_start + pre), 1'b0);
          last_mark = ev.stamp;
          put_sample(CAT_TMEM, frame_slot, ev.tmem, 1'b0);
          put_sample(CAT_CMD, frame_slot, ev.cmd, 1'b0);
          put_sample(CAT_PIPE, frame_slot, ev.pipe, 1'b1);
        end
        default: begin
          frame_slot  = (frame_slot + 1) % WIN_DEPTH;
          preempt     = '0;
          frame_start = ev.stamp;
          last_mark   = ev.stamp;
        end
      endcase
    endfunction

    function void check_sample(win_result_t got);
      win_result_t exp;
      if (pending_samples.size() == 0) begin
        $error("result with no expectation: cat %0d value %0h", got.cat, got.value);
        errors++;
        return;
      end
      exp = pending_samples.pop_front();
      if (got.cat !== exp.cat) begin
        $error("out_category: expected %0d, got %0d", exp.cat, got.cat);
        errors++;
      end
      if (got.value !== exp.value) begin
        $error("sample_value: expected %0h, got %0h", exp.value, got.value);
        errors++;
      end
      if (got.total !== exp.total) begin
        $error("window_total: expected %0h, got %0h", exp.total, got.total);
        errors++;
      end
      if (got.average !== exp.average) begin
        $error("window_average: expected %0h, got %0h", exp.average, got.average);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("last_result: expected %0b, got %0b", exp.last, got.last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pending_samples.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  wsp_in_if  in_ch();
  wsp_out_if out_ch();

  windowed_section_time_profiler #(.WINDOW_DEPTH(WIN_DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  window_scoreboard sb = new();

  int unsigned items_sent  = 0;
  int unsigned burst_left  = 0;
  bit          gaps_on     = 1'b1;
  bit          hold_off_req = 1'b0;
  word_t       now;
  longint unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin : result_monitor
    win_result_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.cat     = out_ch.out_category;
      got.value   = out_ch.sample_value;
      got.total   = out_ch.window_total;
      got.average = out_ch.window_average;
      got.last    = out_ch.last_result;
      sb.check_sample(got);
    end
  end

  // receiver: random stall patterns in segments, plus one long hold-off on request
  initial begin : result_sink
    int unsigned seg_left;
    int unsigned mode;
    int unsigned hold_left;
    int unsigned phase;
    seg_left  = 0;
    mode      = 0;
    hold_left = 0;
    phase     = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          mode     = $urandom_range(0, 3);
          seg_left = $urandom_range(20, 200);
        end
        seg_left--;
        phase++;
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= (phase % 5 != 4);
        endcase
      end
    end
  end

  function automatic prof_event_t mk_event(req_type_t kind, int unsigned category,
                                           logic rsp_id, word_t stamp,
                                           word_t tmem = '0, word_t cmd = '0,
                                           word_t pipe = '0);
    prof_event_t ev;
    ev.kind     = kind;
    ev.category = cat_t'(category);
    ev.rsp_id   = rsp_id;
    ev.stamp    = stamp;
    ev.tmem     = tmem;
    ev.cmd      = cmd;
    ev.pipe     = pipe;
    return ev;
  endfunction

  // sender: bursts of random length, random gaps between them when gaps_on
  task automatic drive_event(prof_event_t ev);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on) begin
        gap = $urandom_range(1, 8);
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= ev.kind;
    in_ch.category   <= ev.category;
    in_ch.rsp_task   <= ev.rsp_id;
    in_ch.timestamp  <= ev.stamp;
    in_ch.tmem_count <= ev.tmem;
    in_ch.cmd_count  <= ev.cmd;
    in_ch.pipe_count <= ev.pipe;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    sb.note_event(ev);
    burst_left--;
    if (!(ev.kind == REQ_SECTION_END && ev.category >= CAT_COUNT)) items_sent++;
  endtask

  task automatic advance_time();
    if ($urandom_range(0, 19) == 0) now = now + $urandom;
    else now = now + $urandom_range(1, 3000);
  endtask

  function automatic word_t rdp_count();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  // one well-formed frame: setup, a few timed sections, frame end
  task automatic run_frame();
    int unsigned n_parts;
    int unsigned n_resume;
    logic        id;
    advance_time();
    drive_event(mk_event(REQ_FRAME_SETUP, 0, 1'($urandom_range(0, 1)), now));
    n_parts = $urandom_range(1, 6);
    repeat (n_parts) begin
      advance_time();
      case ($urandom_range(0, 3))
        0, 1: drive_event(mk_event(REQ_SECTION_END, $urandom_range(0, NUM_CATS - 1),
                                   1'($urandom_range(0, 1)), now));
        2: begin
          drive_event(mk_event(REQ_AUDIO_START, $urandom_range(0, 15), 1'b0, now));
          advance_time();
          drive_event(mk_event(REQ_AUDIO_DONE, $urandom_range(0, 15), 1'b1, now));
        end
        default: begin
          id = 1'($urandom_range(0, 1));
          drive_event(mk_event(REQ_RSP_START, $urandom_range(0, 15), id, now));
          n_resume = $urandom_range(0, 2);
          repeat (n_resume) begin
            advance_time();
            drive_event(mk_event(REQ_RSP_RESUME, $urandom_range(0, 15),
                                 1'($urandom_range(0, 1)), now));
          end
          advance_time();
          drive_event(mk_event(REQ_RSP_DONE, $urandom_range(0, 15), id, now));
        end
      endcase
    end
    advance_time();
    drive_event(mk_event(REQ_FRAME_END, $urandom_range(0, 15), 1'($urandom_range(0, 1)),
                         now, rdp_count(), rdp_count(), rdp_count()));
  endtask

  // noise and broken sequences: any event with any field values
  task automatic run_noise();
    int unsigned n;
    n = $urandom_range(1, 4);
    repeat (n) begin
      drive_event(mk_event(req_type_t'($urandom_range(0, 7)), $urandom_range(0, 15),
                           1'($urandom_range(0, 1)), $urandom,
                           $urandom, $urandom, $urandom));
    end
  endtask

  initial begin : stimulus
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.req_type   <= REQ_SECTION_END;
    in_ch.category   <= '0;
    in_ch.rsp_task   <= 1'b0;
    in_ch.timestamp  <= '0;
    in_ch.tmem_count <= '0;
    in_ch.cmd_count  <= '0;
    in_ch.pipe_count <= '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // directed: section before any frame setup, slot wrap of the frame index
    drive_event(mk_event(REQ_SECTION_END, 0, 1'b0, 32'd100));
    drive_event(mk_event(REQ_FRAME_SETUP, 0, 1'b0, 32'd200));
    drive_event(mk_event(REQ_SECTION_END, 12, 1'b1, 32'hFFFF_FFF0));
    // categories past the last one are ignored
    drive_event(mk_event(REQ_SECTION_END, 13, 1'b0, 32'd5));
    drive_event(mk_event(REQ_SECTION_END, 15, 1'b1, 32'd7));
    drive_event(mk_event(REQ_RSP_START, 0, 1'b0, 32'd1000));
    // resume hits the graphics task even with rsp_task set
    drive_event(mk_event(REQ_RSP_RESUME, 0, 1'b1, 32'd1500));
    drive_event(mk_event(REQ_RSP_RESUME, 0, 1'b0, 32'd3000));
    drive_event(mk_event(REQ_RSP_DONE, 0, 1'b0, 32'd0));
    drive_event(mk_event(REQ_RSP_START, 0, 1'b1, 32'hFFFF_FFFF));
    drive_event(mk_event(REQ_RSP_DONE, 0, 1'b1, 32'd10));
    drive_event(mk_event(REQ_AUDIO_START, 0, 1'b0, 32'd4000));
    drive_event(mk_event(REQ_AUDIO_DONE, 0, 1'b0, 32'd4600));
    // section with preempted audio time pending
    drive_event(mk_event(REQ_SECTION_END, 3, 1'b0, 32'd5000));
    drive_event(mk_event(REQ_AUDIO_START, 0, 1'b0, 32'd5100));
    drive_event(mk_event(REQ_AUDIO_DONE, 0, 1'b0, 32'd5000));
    drive_event(mk_event(REQ_FRAME_END, 0, 1'b0, 32'd9000, '0, '0, '0));
    drive_event(mk_event(REQ_FRAME_SETUP, 0, 1'b0, 32'd10000));
    drive_event(mk_event(REQ_FRAME_END, 0, 1'b1, 32'hFFFF_FFFF, '1, '1, '1));
    drive_event(mk_event(REQ_RSP_DONE, 0, 1'b0, 32'd20000));
    drive_event(mk_event(REQ_SECTION_END, 7, 1'b0, 32'd21000));

    now = $urandom;

    // long receiver hold-off while the sender keeps offering items
    gaps_on      = 1'b0;
    hold_off_req = 1'b1;
    run_frame();
    run_frame();

    while (items_sent < ITEM_TARGET) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0) run_noise();
      else run_frame();
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/wsp_pkg.sv
hw/rtl/wsp_ifs.sv
hw/rtl/wsp_ram.sv
hw/rtl/wsp_avg.sv
hw/rtl/wsp_window.sv
hw/rtl/windowed_section_time_profiler.sv
tb/tb_windowed_section_time_profiler.sv
